// ===== hdl/pds_pkg.sv =====
// Package for the PLL divider search unit: request/result payload types,
// register indexes, post-divider table and sequencer states. No dependencies.
`default_nettype none
package pds_pkg;

	localparam int IN_W   = 17;
	localparam int WANT_W = 18;
	localparam int VCO_W  = 20;
	localparam int DIV_W  = 8;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W  = 20;
	localparam int DIVU_W = 28;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_IN_MIN  = 3'd0,
		REG_IN_MAX  = 3'd1,
		REG_REF_MIN = 3'd2,
		REG_REF_MAX = 3'd3,
		REG_VCO_MIN = 3'd4,
		REG_VCO_MAX = 3'd5,
		REG_OD_MIN  = 3'd6,
		REG_OD_MAX  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_EXACT   = 2'd0,
		ST_NEAREST = 2'd1,
		ST_NONE    = 2'd2
	} status_t;

	typedef struct packed {
		logic [IN_W-1:0]   in_clock;
		logic [WANT_W-1:0] want_clock;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [WANT_W-1:0] achieved_clock;
		logic [DIV_W-1:0]  mult_m;
		logic [DIV_W-1:0]  div_n;
		logic [DIV_W-1:0]  out_divider;
		logic              od_low;
		logic              od_high;
	} rsp_t;

	typedef struct packed {
		logic [DIVU_W-1:0] num;
		logic [DIVU_W-1:0] den;
	} div_req_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_NMIN, S_NMAX, S_MMAX, S_MMIN, S_LOOP,
		S_PROD, S_DIV1, S_DIV2, S_CMP, S_NEXT, S_DONE
	} seq_state_t;

	// post-divider shift (log2 NO) for table entry j; select bits are j itself
	function automatic logic [1:0] no_shift(input logic [1:0] j);
		return j;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/pds_divider.sv =====
// Shared restoring divider, one quotient bit a cycle; uses pds_pkg.
// Division by zero returns all ones.
`default_nettype none
module pds_divider
	import pds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire div_req_t          req,
	output logic                   busy,
	output logic [DIVU_W-1:0]      quot
);
	localparam int CW = $clog2(DIVU_W + 1);

	logic [DIVU_W-1:0] rem_q, num_q, den_q, quot_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [DIVU_W:0]   trial;

	assign trial = {rem_q, num_q[DIVU_W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DIVU_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			num_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIVU_W-2:0], 1'b0};
			if (!trial[DIVU_W]) begin
				rem_q  <= trial[DIVU_W-1:0];
				quot_q <= {quot_q[DIVU_W-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[DIVU_W-2:0], num_q[DIVU_W-1]};
				quot_q <= {quot_q[DIVU_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

// ===== hdl/pds_multiplier.sv =====
// Registered multiplier shared by the range setup and candidate steps;
// uses pds_pkg. Product is ready the cycle after the operands.
`default_nettype none
module pds_multiplier
	import pds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [VCO_W-1:0]  a,
	input  wire logic [DIV_W-1:0]  b,
	output logic [DIVU_W-1:0]      p
);
	logic [DIVU_W-1:0] p_q;
	always_ff @(posedge clk) begin
		p_q <= DIVU_W'(a) * DIVU_W'(b);
	end
	assign p = p_q;
endmodule
`default_nettype wire

// ===== hdl/pll_divider_search_unit.sv =====
// Top level of the PLL divider search unit: config registers, sequencer,
// shared divider and multiplier. Depends on pds_pkg, pds_divider, pds_multiplier.
//
// channel | direction | signals
// --------+-----------+-----------------------------------------------
// cfg     | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
// req     | in        | req_valid, req_ready, req (in_clock, want_clock)
// rsp     | out       | rsp_valid, rsp_ready, rsp (status, clock, settings)
//
// Setup takes two divisions for the n bounds and two for the m bounds (product first),
// then one product and two divisions per candidate over outdiv x 4 x n x m; a skipped
// candidate does not use the shared bit-serial divider. A rejected request goes from
// the check straight to the result.
// Reset clears the sequencer and loads the register defaults. A stalled result
// holds in the output register; the next request is taken once it is accepted.
`default_nettype none
module pll_divider_search_unit
	import pds_pkg::*;
#(
	parameter int N_LOW  = 1,
	parameter int N_HIGH = 63,
	parameter int M_LOW  = 2,
	parameter int M_HIGH = 255
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire req_t                 req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output rsp_t                      rsp
);
	// configuration registers
	logic [IN_W-1:0]  in_min_q, in_max_q, ref_min_q, ref_max_q;
	logic [VCO_W-1:0] vco_min_q, vco_max_q;
	logic [DIV_W-1:0] od_min_q, od_max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_min_q  <= IN_W'(2000);
			in_max_q  <= IN_W'(50000);
			ref_min_q <= IN_W'(1000);
			ref_max_q <= IN_W'(15000);
			vco_min_q <= VCO_W'(100000);
			vco_max_q <= VCO_W'(500000);
			od_min_q  <= DIV_W'(1);
			od_max_q  <= DIV_W'(16);
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IN_MIN:  in_min_q  <= cfg_data[IN_W-1:0];
				REG_IN_MAX:  in_max_q  <= cfg_data[IN_W-1:0];
				REG_REF_MIN: ref_min_q <= cfg_data[IN_W-1:0];
				REG_REF_MAX: ref_max_q <= cfg_data[IN_W-1:0];
				REG_VCO_MIN: vco_min_q <= cfg_data[VCO_W-1:0];
				REG_VCO_MAX: vco_max_q <= cfg_data[VCO_W-1:0];
				REG_OD_MIN:  od_min_q  <= cfg_data[DIV_W-1:0];
				REG_OD_MAX:  od_max_q  <= cfg_data[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// search state
	seq_state_t state_q, state_d;
	logic [IN_W-1:0]   clk_q;
	logic [WANT_W:0]   target_q;
	logic [WANT_W:0]   best_q;
	logic [DIV_W-1:0]  nmin_q, nmax_q, mmin_q, mmax_q, od_q, p_q, m_q;
	logic [1:0]        j_q;
	logic [DIVU_W-1:0] cand_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	// shared units
	logic              div_start, div_busy;
	div_req_t          div_req;
	logic [DIVU_W-1:0] quot, prod;
	logic [VCO_W-1:0]  mul_a;
	logic [DIV_W-1:0]  mul_b;

	pds_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .req(div_req),
		.busy(div_busy), .quot(quot)
	);

	pds_multiplier u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

	// clamp a quotient to [lo, hi]
	function automatic logic [DIV_W-1:0] clampq(input logic [DIVU_W-1:0] x,
		input int lo, input int hi);
		logic [DIVU_W-1:0] r;
		r = x;
		if (r < DIVU_W'(lo)) r = DIVU_W'(lo);
		if (r > DIVU_W'(hi)) r = DIVU_W'(hi);
		return r[DIV_W-1:0];
	endfunction

	logic [DIVU_W-1:0] diff;
	assign diff = (cand_q > DIVU_W'(target_q)) ? cand_q - DIVU_W'(target_q)
		: DIVU_W'(target_q) - cand_q;

	assign req_ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MMAX: begin mul_a = vco_max_q; mul_b = nmax_q; end
			S_MMIN: begin mul_a = vco_min_q; mul_b = nmin_q; end
			default: begin mul_a = VCO_W'(clk_q); mul_b = m_q; end
		endcase
	end

	// sub-step flag inside the dividing states: 0 = issue, 1 = wait; the m bounds issue in 1
	logic phase_q;
	logic phase2_q;

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_req   = '0;
		unique case (state_q)
			S_IDLE:  if (req_valid && req_ready) state_d = S_CHECK;
			S_CHECK: begin
				if (clk_q == '0 || clk_q < in_min_q || clk_q > in_max_q)
					state_d = S_DONE;
				else
					state_d = S_NMIN;
			end
			S_NMIN, S_NMAX: begin
				div_req.num = DIVU_W'(clk_q);
				div_req.den = DIVU_W'(state_q == S_NMIN ? ref_max_q : ref_min_q);
				div_start = !phase_q;
				if (phase_q && !div_busy)
					state_d = (state_q == S_NMIN) ? S_NMAX : S_MMAX;
			end
			S_MMAX, S_MMIN: begin
				// product registered in phase 0, division in phase 1
				div_req.num = prod;
				div_req.den = DIVU_W'(clk_q);
				div_start = phase_q && !div_busy && !phase2_q;
				if (phase2_q && !div_busy && !div_start)
					state_d = (state_q == S_MMAX) ? S_MMIN : S_LOOP;
			end
			S_LOOP: begin
				if (od_q >= od_max_q)
					state_d = S_DONE;
				else if (od_q == '0 || p_q >= nmax_q || m_q >= mmax_q)
					state_d = S_NEXT;
				else
					state_d = S_PROD;
			end
			S_PROD: state_d = S_DIV1;
			S_DIV1: begin
				div_req.num = prod;
				div_req.den = DIVU_W'(p_q);
				div_start = !phase_q;
				if (phase_q && !div_busy) state_d = S_DIV2;
			end
			S_DIV2: begin
				div_req.num = quot >> no_shift(j_q);
				div_req.den = DIVU_W'(od_q);
				div_start = !phase_q;
				if (phase_q && !div_busy) state_d = S_CMP;
			end
			S_CMP: state_d = (diff == '0) ? S_DONE : S_NEXT;
			S_NEXT: state_d = S_LOOP;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			phase_q     <= 1'b0;
			phase2_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				phase_q  <= 1'b0;
				phase2_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
				if (div_start && phase_q) phase2_q <= 1'b1;
			end
			if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
			if (state_q == S_DONE) rsp_valid_q <= 1'b1;
		end
	end

	// datapath: hold request, walk indices, track best candidate
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (req_valid && req_ready) begin
				clk_q    <= req.in_clock;
				target_q <= {req.want_clock, 1'b0};
				best_q   <= {req.want_clock, 1'b0};
				rsp_q    <= '{status: ST_NONE, default: '0};
			end
			S_NMIN: if (phase_q && !div_busy) nmin_q <= clampq(quot, N_LOW, N_HIGH);
			S_NMAX: if (phase_q && !div_busy) nmax_q <= clampq(quot, N_LOW, N_HIGH);
			S_MMAX: if (phase2_q && !div_busy && state_d != state_q)
				mmax_q <= clampq(quot, M_LOW, M_HIGH);
			S_MMIN: if (phase2_q && !div_busy && state_d != state_q) begin
				mmin_q <= clampq(quot, M_LOW, M_HIGH);
				od_q   <= od_min_q;
				j_q    <= '0;
				p_q    <= nmin_q;
				m_q    <= clampq(quot, M_LOW, M_HIGH);
			end
			S_DIV2: if (phase_q && !div_busy) cand_q <= quot;
			S_CMP: begin
				if (diff == '0 || diff < DIVU_W'(best_q)) begin
					best_q  <= diff[WANT_W:0];
					rsp_q.achieved_clock <= (cand_q[DIVU_W-1:1] > (DIVU_W-1)'(18'h3FFFF))
						? 18'h3FFFF : cand_q[WANT_W:1];
					rsp_q.mult_m      <= m_q;
					rsp_q.div_n       <= p_q;
					rsp_q.out_divider <= od_q;
					rsp_q.od_low      <= j_q[0];
					rsp_q.od_high     <= j_q[1];
					rsp_q.status      <= (diff == '0) ? ST_EXACT : ST_NEAREST;
				end
			end
			S_NEXT: begin
				// advance m, then n, then NO, then output divider
				if (od_q != '0 && p_q < nmax_q && {1'b0, m_q} + 9'd1 < {1'b0, mmax_q}) begin
					m_q <= m_q + 1'b1;
				end else begin
					m_q <= mmin_q;
					if (od_q != '0 && p_q + 1'b1 < nmax_q) begin
						p_q <= p_q + 1'b1;
					end else begin
						p_q <= nmin_q;
						if (od_q != '0 && j_q != 2'd3) j_q <= j_q + 1'b1;
						else begin
							j_q  <= '0;
							od_q <= od_q + 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for pll_divider_search_unit: drives configuration writes and search
// requests, predicts each divider setting in SystemVerilog and checks every result.
// Depends on pds_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb_top;
	import pds_pkg::*;

	localparam int N_LO = 1;
	localparam int N_HI = 63;
	localparam int M_LO = 2;
	localparam int M_HI = 255;
	// most candidates a search may walk; keep each search modest
	localparam int CAND_BUDGET = 250;
	localparam int IDLE_LIMIT  = 100000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 req_valid;
	logic                 req_ready;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	rsp_t                 rsp;

	longint unsigned setting [8];
	rsp_t            expected_settings [$];
	int              error_count;
	int              idle_cycles;

	pll_divider_search_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// -------------------------------------------------------------------
	// Prediction
	// -------------------------------------------------------------------
	function automatic longint unsigned clamp_to(longint unsigned x, longint unsigned lo,
			longint unsigned hi);
		if (x < lo)
			x = lo;
		if (x > hi)
			x = hi;
		return x;
	endfunction

	// a zero divisor yields the largest value, which the clamp then bounds
	function automatic longint unsigned sat_div(longint unsigned a, longint unsigned b);
		if (b == 0)
			return 64'hFFFF_FFFF_FFFF_FFFF;
		return a / b;
	endfunction

	function automatic void search_bounds(input longint unsigned fin,
			output longint unsigned nmin, output longint unsigned nmax,
			output longint unsigned mmin, output longint unsigned mmax);
		nmin = clamp_to(sat_div(fin, setting[REG_REF_MAX]), N_LO, N_HI);
		nmax = clamp_to(sat_div(fin, setting[REG_REF_MIN]), N_LO, N_HI);
		mmax = clamp_to(setting[REG_VCO_MAX] * nmax / fin, M_LO, M_HI);
		mmin = clamp_to(setting[REG_VCO_MIN] * nmin / fin, M_LO, M_HI);
	endfunction

	function automatic bit in_window(longint unsigned fin);
		return fin != 0 && fin >= setting[REG_IN_MIN] && fin <= setting[REG_IN_MAX];
	endfunction

	// upper bound on the candidates a search walks
	function automatic longint unsigned candidate_count(longint unsigned fin);
		longint unsigned nmin, nmax, mmin, mmax, ods;
		if (!in_window(fin))
			return 0;
		search_bounds(fin, nmin, nmax, mmin, mmax);
		if (nmax <= nmin || mmax <= mmin || setting[REG_OD_MAX] <= setting[REG_OD_MIN])
			return 0;
		ods = setting[REG_OD_MAX] - setting[REG_OD_MIN];
		return ods * 4 * (nmax - nmin) * (mmax - mmin);
	endfunction

	function automatic rsp_t predict_setting(req_t r);
		rsp_t            res;
		longint unsigned fin, target, best, nmin, nmax, mmin, mmax, c, d, half;
		bit              found;
		res        = '0;
		res.status = ST_NONE;
		fin        = r.in_clock;
		target     = longint'(r.want_clock) << 1;
		best       = target;
		found      = 1'b0;
		if (!in_window(fin))
			return res;
		search_bounds(fin, nmin, nmax, mmin, mmax);
		for (longint unsigned od = setting[REG_OD_MIN]; od < setting[REG_OD_MAX]; od++) begin
			if (od == 0)
				continue;
			for (int j = 0; j < 4; j++) begin
				for (longint unsigned n = nmin; n < nmax; n++) begin
					for (longint unsigned m = mmin; m < mmax; m++) begin
						c = ((fin * m) / n) / (longint'(1) << j) / od;
						d = (c > target) ? c - target : target - c;
						if (d == 0 || d < best) begin
							half               = c >> 1;
							best               = d;
							found              = 1'b1;
							res.achieved_clock = (half > 262143) ? 18'h3FFFF : half[17:0];
							res.mult_m         = m[7:0];
							res.div_n          = n[7:0];
							res.out_divider    = od[7:0];
							res.od_low         = j[0];
							res.od_high        = j[1];
							if (d == 0) begin
								res.status = ST_EXACT;
								return res;
							end
						end
					end
				end
			end
		end
		if (found)
			res.status = ST_NEAREST;
		return res;
	endfunction

	// -------------------------------------------------------------------
	// Drivers
	// -------------------------------------------------------------------
	function automatic int random_gap();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 8)
			return 0;
		if (pick < 18)
			return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// write one register; only called with nothing outstanding
	task automatic write_setting(reg_idx_t idx, longint unsigned value);
		longint unsigned mask;
		case (idx)
			REG_VCO_MIN, REG_VCO_MAX: mask = 64'hFFFFF;
			REG_OD_MIN, REG_OD_MAX:   mask = 64'hFF;
			default:                  mask = 64'h1FFFF;
		endcase
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		setting[idx] = value & mask;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(longint unsigned in_lo, longint unsigned in_hi,
			longint unsigned rf_lo, longint unsigned rf_hi, longint unsigned vc_lo,
			longint unsigned vc_hi, longint unsigned od_lo, longint unsigned od_hi);
		// drain, then let the block settle before touching the registers
		wait (expected_settings.size() == 0);
		repeat (20) @(posedge clk);
		write_setting(REG_IN_MIN, in_lo);
		write_setting(REG_IN_MAX, in_hi);
		write_setting(REG_REF_MIN, rf_lo);
		write_setting(REG_REF_MAX, rf_hi);
		write_setting(REG_VCO_MIN, vc_lo);
		write_setting(REG_VCO_MAX, vc_hi);
		write_setting(REG_OD_MIN, od_lo);
		write_setting(REG_OD_MAX, od_hi);
	endtask

	// hold valid across back-to-back requests; drop it only for a gap
	task automatic send_request(logic [IN_W-1:0] fin, logic [WANT_W-1:0] want);
		req_t r;
		int   gap;
		r.in_clock   = fin;
		r.want_clock = want;
		gap          = random_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		expected_settings.push_back(predict_setting(r));
	endtask

	task automatic end_requests();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	// -------------------------------------------------------------------
	// Result check and receiver stalls
	// -------------------------------------------------------------------
	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("%0t result %s: got %0d, expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_settings.size() == 0) begin
					report_mismatch("with nothing expected, status", rsp.status, 0);
				end else begin
					e = expected_settings.pop_front();
					if (rsp.status != e.status)
						report_mismatch("status", rsp.status, e.status);
					if (rsp.achieved_clock != e.achieved_clock)
						report_mismatch("achieved_clock", rsp.achieved_clock, e.achieved_clock);
					if (rsp.mult_m != e.mult_m)
						report_mismatch("mult_m", rsp.mult_m, e.mult_m);
					if (rsp.div_n != e.div_n)
						report_mismatch("div_n", rsp.div_n, e.div_n);
					if (rsp.out_divider != e.out_divider)
						report_mismatch("out_divider", rsp.out_divider, e.out_divider);
					if (rsp.od_low != e.od_low)
						report_mismatch("od_low", rsp.od_low, e.od_low);
					if (rsp.od_high != e.od_high)
						report_mismatch("od_high", rsp.od_high, e.od_high);
				end
			end
			// stall in runs: mostly short, now and then long, sometimes none at all
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if ($urandom_range(0, 2) == 0) begin
				stall_left = random_gap();
				rsp_ready <= (stall_left == 0);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// watchdog: a long stretch with no handshake on any channel ends the run
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("pll_divider_search_unit: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// -------------------------------------------------------------------
	// Tests
	// -------------------------------------------------------------------
	// reset values: only rejected requests, a full default search is far too long
	task automatic test_reset_window();
		send_request(17'd0, 18'd1000);
		send_request(17'd1999, 18'd5000);
		send_request(17'd50001, 18'h3FFFF);
		send_request(17'h1FFFF, 18'd0);
	endtask

	task automatic test_field_extremes();
		load_settings(1, 131071, 10000, 12000, 200000, 220000, 1, 3);
		send_request(17'd20000, 18'd0);
		send_request(17'd20000, 18'h3FFFF);
		send_request(17'd20000, 18'd50000);
		send_request(17'd20000, 18'd37000);
		send_request(17'h1FFFF, 18'h3FFFF);
		send_request(17'h1FFFF, 18'd0);
		send_request(17'h1FFFF, 18'd100000);
		send_request(17'd1, 18'd1);
		send_request(17'd0, 18'd100);
		end_requests();
	endtask

	// zero ref limits saturate the division; the clamp leaves an empty n range
	task automatic test_zero_ref();
		load_settings(0, 131071, 0, 0, 200000, 220000, 1, 3);
		send_request(17'd0, 18'd100);
		send_request(17'd30000, 18'd100);
		end_requests();
	endtask

	// output divider of zero is skipped; upper data bits beyond a register drop
	task automatic test_zero_outdiv();
		load_settings(64'hE0000 | 1, 131071, 10000, 12000, 200000, 220000, 0, 2);
		send_request(17'd20000, 18'd60000);
		send_request(17'd20000, 18'd12345);
		end_requests();
	endtask

	// a far-off nearest clock whose half no longer fits: n is 1 only, m is 5 only
	task automatic test_wide_clock();
		load_settings(1, 131071, 65535, 131071, 655355, 400000, 1, 2);
		send_request(17'h1FFFF, 18'h3FFFF);
		send_request(17'h1FFFF, 18'd200000);
		end_requests();
	endtask

	// wanted clock zero matches a candidate that truncates to zero
	task automatic test_want_zero();
		load_settings(1, 131071, 50, 100, 200, 300, 200, 202);
		send_request(17'd100, 18'd0);
		send_request(17'd100, 18'd1);
		end_requests();
	endtask

	// pick a wanted clock: on a reachable candidate, beside one, or anywhere
	function automatic logic [WANT_W-1:0] pick_want(longint unsigned fin);
		longint unsigned nmin, nmax, mmin, mmax, od, n, m, c;
		int              j, mode;
		mode = $urandom_range(0, 3);
		if (mode == 3 || candidate_count(fin) == 0)
			return WANT_W'($urandom());
		search_bounds(fin, nmin, nmax, mmin, mmax);
		od = setting[REG_OD_MIN] + $urandom_range(0, setting[REG_OD_MAX] - setting[REG_OD_MIN] - 1);
		if (od == 0)
			od = 1;
		j = $urandom_range(0, 3);
		n = nmin + $urandom_range(0, nmax - nmin - 1);
		m = mmin + $urandom_range(0, mmax - mmin - 1);
		c = ((fin * m) / n) / (longint'(1) << j) / od;
		c = c >> 1;
		if (mode == 2)
			c = c + $urandom_range(0, 6) - 3;
		return c[WANT_W-1:0];
	endfunction

	task automatic random_phase(int items, bit extreme);
		longint unsigned in_lo, in_hi, rf_lo, rf_hi, vc_lo, vc_hi, od_lo, od_hi, fin;
		int              tries;
		if (extreme) begin
			in_lo = 1;
			in_hi = 131071;
			rf_lo = $urandom_range(60000, 131071);
			rf_hi = 131071;
			vc_lo = $urandom_range(1, 1048575);
			vc_hi = 1048575;
			od_lo = 254;
			od_hi = 255;
		end else begin
			in_lo = $urandom_range(1, 60000);
			in_hi = in_lo + $urandom_range(0, 71071);
			rf_lo = $urandom_range(2000, 131071);
			rf_hi = rf_lo + $urandom_range(0, rf_lo);
			if (rf_hi > 131071)
				rf_hi = 131071;
			vc_lo = $urandom_range(1, 1048575);
			vc_hi = vc_lo + $urandom_range(0, vc_lo / 4);
			if (vc_hi > 1048575)
				vc_hi = 1048575;
			od_lo = $urandom_range(0, 8);
			od_hi = od_lo + $urandom_range(0, 3);
		end
		load_settings(in_lo, in_hi, rf_lo, rf_hi, vc_lo, vc_hi, od_lo, od_hi);
		for (int i = 0; i < items; i++) begin
			// mostly in-window clocks, with a few rejects; keep each search short
			tries = 0;
			do begin
				if ($urandom_range(0, 9) == 0)
					fin = $urandom_range(0, 131071);
				else
					fin = $urandom_range(in_lo, (in_hi > 131071) ? 131071 : in_hi);
				tries++;
			end while (candidate_count(fin) > CAND_BUDGET && tries < 40);
			if (candidate_count(fin) > CAND_BUDGET)
				fin = 0;
			send_request(fin[IN_W-1:0], pick_want(fin));
		end
		end_requests();
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		req_valid   = 1'b0;
		req         = '0;
		error_count = 0;
		idle_cycles = 0;
		setting[REG_IN_MIN]  = 2000;
		setting[REG_IN_MAX]  = 50000;
		setting[REG_REF_MIN] = 1000;
		setting[REG_REF_MAX] = 15000;
		setting[REG_VCO_MIN] = 100000;
		setting[REG_VCO_MAX] = 500000;
		setting[REG_OD_MIN]  = 1;
		setting[REG_OD_MAX]  = 16;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		end_requests();
		test_field_extremes();
		test_zero_ref();
		test_zero_outdiv();
		test_wide_clock();
		test_want_zero();
		random_phase(25, 1'b0);
		random_phase(25, 1'b0);
		random_phase(15, 1'b1);
		random_phase(35, 1'b0);

		wait (expected_settings.size() == 0);
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("pll_divider_search_unit: match");
		else
			$display("pll_divider_search_unit: mismatch");
		$finish;
	end

endmodule
